// ----- sv/length_crc_frame_parser_macros.svh -----
// Assertion macros for the length/CRC frame parser.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef LENGTH_CRC_FRAME_PARSER_MACROS_SVH
`define LENGTH_CRC_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define LCFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcfp: assertion failed");

// next-cycle implication
`define LCFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcfp: assertion failed");

`endif

// ----- sv/lcfp_pkg.sv -----
// Shared types, constants and the CRC-16/Modbus byte step for the frame parser.
// No dependencies.
package lcfp_pkg;

    localparam logic [7:0]  FRAME_HEADER = 8'h22;
    localparam logic [7:0]  MIN_LEN      = 8'd5;
    localparam int          RESULT_CAP   = 64;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    typedef struct packed {
        logic       flush;
        logic [7:0] rx_byte;
    } lcfp_item_t;

    typedef struct packed {
        logic [7:0] func_code;
        logic [5:0] data_length;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last;
    } lcfp_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEN_RD,
        ST_LEN_CHK,
        ST_CRC_RD,
        ST_CRC_UPD,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } lcfp_state_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- sv/lcfp_front.sv -----
// Input queue: takes items off the slave stream and holds them for the parser.
// Depends on lcfp_pkg.
module lcfp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lcfp_pkg::lcfp_item_t in_item,
    output logic                out_valid,
    input  logic                out_pop,
    output lcfp_pkg::lcfp_item_t out_item
);
    import lcfp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    lcfp_item_t     mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;
    logic           push;
    logic           pop;

    assign in_ready  = (count_reg != (PW+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- sv/lcfp_engine.sv -----
// Parser back end: byte window memory, length/header/CRC checks and result emission.
// Depends on lcfp_pkg; fed by lcfp_front.
module lcfp_engine #(
    parameter int MAX_FRAME = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  lcfp_pkg::lcfp_item_t  in_item,
    output logic                  in_pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output lcfp_pkg::lcfp_result_t res
);
    import lcfp_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);
    localparam int FW = $clog2(MAX_FRAME + 1);
    localparam logic [AW+1:0] MAX_W   = (AW+2)'(MAX_FRAME);
    localparam logic [8:0]    LEN_TOP = 9'(MAX_FRAME - 1);

    function automatic logic [AW-1:0] wrap_add(input logic [AW:0] a, input logic [AW:0] b);
        logic [AW+1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MAX_W)
        begin
            s = s - MAX_W;
        end
        return s[AW-1:0];
    endfunction

    logic [7:0]    win [MAX_FRAME];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    lcfp_state_t   state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] off_reg, off_next;
    logic [7:0]    len_reg, len_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    rx_lo_reg, rx_lo_next;
    logic [7:0]    rx_hi_reg, rx_hi_next;
    logic          hdr_ok_reg, hdr_ok_next;
    logic [7:0]    func_reg, func_next;
    logic [7:0]    idx_reg, idx_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          res_valid_reg, res_valid_next;
    lcfp_result_t  res_reg, res_next;

    logic          can_load;
    logic          below_cap;
    logic [7:0]    dlen;
    logic [8:0]    off9;
    logic [8:0]    len9;
    logic          is_last;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign rd_addr   = wrap_add((AW+1)'(start_reg), (AW+1)'(off_reg));
    assign can_load  = !res_valid_reg || res_ready;
    assign below_cap = (cnt_reg < 7'(RESULT_CAP));
    assign dlen      = len_reg - MIN_LEN;
    assign off9      = 9'(off_reg);
    assign len9      = {1'b0, len_reg};
    assign is_last   = (dlen == 8'd0) || (idx_reg + 8'd1 == dlen);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        start_next     = start_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        rx_lo_next     = rx_lo_reg;
        rx_hi_next     = rx_hi_reg;
        hdr_ok_next    = hdr_ok_reg;
        func_next      = func_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        in_pop         = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = wrap_add((AW+1)'(start_reg), (AW+1)'(fill_reg));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_pop = 1'b1;
                    if (in_item.flush)
                    begin
                        fill_next  = '0;
                        start_next = '0;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        cnt_next = '0;
                        if (fill_reg == FW'(MAX_FRAME))
                        begin
                            wr_addr    = start_reg;
                            start_next = wrap_add((AW+1)'(start_reg), (AW+1)'(1));
                        end
                        else
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (fill_reg < FW'(MIN_LEN))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    off_next   = AW'(1);
                    state_next = ST_LEN_RD;
                end
            end
            ST_LEN_RD:
            begin
                state_next = ST_LEN_CHK;
            end
            ST_LEN_CHK:
            begin
                if (rd_data_reg < MIN_LEN || {1'b0, rd_data_reg} > LEN_TOP)
                begin
                    fill_next  = fill_reg - 1'b1;
                    start_next = wrap_add((AW+1)'(start_reg), (AW+1)'(1));
                    state_next = ST_SCAN;
                end
                else if (9'(fill_reg) < {1'b0, rd_data_reg})
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    len_next   = rd_data_reg;
                    off_next   = '0;
                    crc_next   = CRC_INIT;
                    state_next = ST_CRC_RD;
                end
            end
            ST_CRC_RD:
            begin
                state_next = ST_CRC_UPD;
            end
            ST_CRC_UPD:
            begin
                if (off_reg == '0)
                begin
                    hdr_ok_next = (rd_data_reg == FRAME_HEADER);
                end
                if (off_reg == AW'(2))
                begin
                    func_next = rd_data_reg;
                end
                if (off9 < len9 - 9'd2)
                begin
                    crc_next = crc_byte(crc_reg, rd_data_reg);
                end
                if (off9 == len9 - 9'd2)
                begin
                    rx_lo_next = rd_data_reg;
                end
                if (off9 == len9 - 9'd1)
                begin
                    rx_hi_next = rd_data_reg;
                    state_next = ST_CHECK;
                end
                else
                begin
                    off_next   = off_reg + 1'b1;
                    state_next = ST_CRC_RD;
                end
            end
            ST_CHECK:
            begin
                if (hdr_ok_reg && crc_reg == {rx_hi_reg, rx_lo_reg})
                begin
                    idx_next   = '0;
                    off_next   = AW'(3);
                    state_next = (dlen == 8'd0) ? ST_EMIT_OUT : ST_EMIT_RD;
                end
                else
                begin
                    fill_next  = fill_reg - 1'b1;
                    start_next = wrap_add((AW+1)'(start_reg), (AW+1)'(1));
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (can_load || !below_cap)
                begin
                    if (below_cap)
                    begin
                        res_valid_next       = 1'b1;
                        res_next.func_code   = func_reg;
                        res_next.data_length = dlen[5:0];
                        res_next.data_byte   = (dlen == 8'd0) ? 8'd0 : rd_data_reg;
                        res_next.byte_index  = idx_reg[5:0];
                        res_next.last        = is_last;
                        cnt_next             = cnt_reg + 1'b1;
                    end
                    if (is_last)
                    begin
                        fill_next  = fill_reg - FW'(len_reg);
                        start_next = wrap_add((AW+1)'(start_reg), (AW+1)'(len_reg));
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        off_next   = off_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            start_reg     <= '0;
            res_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            start_reg     <= start_next;
            res_valid_reg <= res_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg    <= off_next;
        len_reg    <= len_next;
        crc_reg    <= crc_next;
        rx_lo_reg  <= rx_lo_next;
        rx_hi_reg  <= rx_hi_next;
        hdr_ok_reg <= hdr_ok_next;
        func_reg   <= func_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            win[wr_addr] <= in_item.rx_byte;
        end
        rd_data_reg <= win[rd_addr];
    end

endmodule

// ----- sv/length_crc_frame_parser.sv -----
// Top level of the length-prefixed frame parser with CRC-16/Modbus check.
// Depends on lcfp_pkg, lcfp_front, lcfp_engine and the assertion macro header.
//
// Bytes enter on the slave stream into a four-item queue, so the input keeps
// flowing while a result waits on the master stream. The parser takes one byte
// at a time; all window traffic goes through one read port with registered
// data. A byte that settles nothing holds the parser through pop and scan; a
// length decision adds the length read and check, and a byte dropped on a bad
// length is rescanned; a full check of a frame reads and adds each byte in turn,
// then checks; emission reads and outputs each data byte (output only for an
// empty frame) while the output drains. A bad frame drops one byte and rescans,
// repeating that cost per resync step.
// Reset empties the window by clearing its fill count; unwritten entries are
// never read, so no clearing pass is needed.
`include "length_crc_frame_parser_macros.svh"

module length_crc_frame_parser #(
    parameter int MAX_FRAME = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] flush
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] func_code, [13:8] data_length,
                                        // [21:14] data_byte, [27:22] byte_index
    output logic        m_axis_tlast
);
    import lcfp_pkg::*;

    lcfp_item_t   in_item;
    lcfp_item_t   q_item;
    logic         q_valid;
    logic         q_pop;
    lcfp_result_t res;

    assign in_item.rx_byte = s_axis_tdata;
    assign in_item.flush   = s_axis_tuser[0];

    lcfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    lcfp_engine #(
        .MAX_FRAME (MAX_FRAME)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .in_pop    (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {4'h0, res.byte_index, res.data_byte, res.data_length,
                           res.func_code};
    assign m_axis_tlast = res.last;

    `LCFP_ASSERT_NOW(a_marker_shape, m_axis_tvalid && (MAX_FRAME < 70) && m_axis_tdata[13:8] == 6'd0, m_axis_tlast && m_axis_tdata[27:14] == 14'd0)
    `LCFP_ASSERT_NOW(a_last_index, m_axis_tvalid && m_axis_tlast && m_axis_tdata[13:8] != 6'd0, (m_axis_tdata[27:22] + 6'd1) == m_axis_tdata[13:8])
    `LCFP_ASSERT_NEXT(a_pop_needs_item, q_pop, !$past(q_pop) || $past(q_valid))

endmodule

// ----- dv/length_crc_frame_parser_checker.sv -----
// Checker for the frame parser: watches both streams, predicts result items
// from accepted input items and compares them. Depends on lcfp_pkg.
module length_crc_frame_parser_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lcfp_pkg::*;

    localparam int WIN = 64;

    logic [7:0]   win_mem [WIN];
    int unsigned  win_fill;
    int unsigned  win_head;
    lcfp_result_t expected_q [$];

    function automatic logic [7:0] win_byte(int unsigned i);
        return win_mem[(win_head + i) % WIN];
    endfunction

    function automatic void drop_bytes(int unsigned n);
        if (n > win_fill)
            n = win_fill;
        win_head = (win_head + n) % WIN;
        win_fill -= n;
    endfunction

    function automatic logic [15:0] window_crc(int unsigned n);
        logic [15:0] c;
        c = CRC_INIT;
        for (int unsigned i = 0; i < n; i++)
        begin
            c ^= {8'h00, win_byte(i)};
            for (int b = 0; b < 8; b++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void queue_result(logic [7:0] fc, int unsigned dl, logic [7:0] db,
                                         int unsigned idx, logic lst, ref int emitted);
        lcfp_result_t r;
        if (emitted >= RESULT_CAP)
            return;
        r.func_code   = fc;
        r.data_length = dl[5:0];
        r.data_byte   = db;
        r.byte_index  = idx[5:0];
        r.last        = lst;
        expected_q.push_back(r);
        emitted++;
    endfunction

    function automatic void parse_byte(logic [7:0] rx, logic fl);
        int unsigned len;
        int unsigned dl;
        int emitted;
        logic [15:0] rx_crc;
        emitted = 0;
        if (fl)
        begin
            win_fill = 0;
            win_head = 0;
            return;
        end
        if (win_fill >= WIN)
            drop_bytes(1);
        win_mem[(win_head + win_fill) % WIN] = rx;
        win_fill++;
        while (win_fill >= MIN_LEN)
        begin
            len = win_byte(1);
            if (len < MIN_LEN || len > WIN - 1)
            begin
                drop_bytes(1);
                continue;
            end
            if (win_fill < len)
                break;
            rx_crc = {win_byte(len - 1), win_byte(len - 2)};
            if (win_byte(0) != FRAME_HEADER || window_crc(len - 2) != rx_crc)
            begin
                drop_bytes(1);
                continue;
            end
            dl = len - MIN_LEN;
            if (dl == 0)
                queue_result(win_byte(2), 0, 8'h00, 0, 1'b1, emitted);
            else
                for (int unsigned i = 0; i < dl; i++)
                    queue_result(win_byte(2), dl, win_byte(3 + i), i, i + 1 == dl, emitted);
            drop_bytes(len);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lcfp_result_t want;
        if (!rst_n)
        begin
            win_fill   = 0;
            win_head   = 0;
            fail_count = 0;
            expected_q.delete();
            pending    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected item", m_axis_tdata, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.func_code)
                        report_mismatch("func_code", m_axis_tdata[7:0], want.func_code);
                    if (m_axis_tdata[13:8] !== want.data_length)
                        report_mismatch("data_length", m_axis_tdata[13:8], want.data_length);
                    if (m_axis_tdata[21:14] !== want.data_byte)
                        report_mismatch("data_byte", m_axis_tdata[21:14], want.data_byte);
                    if (m_axis_tdata[27:22] !== want.byte_index)
                        report_mismatch("byte_index", m_axis_tdata[27:22], want.byte_index);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", m_axis_tlast, want.last);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tuser[0]);
            pending = expected_q.size();
        end
    end
endmodule

// ----- dv/length_crc_frame_parser_test.sv -----
// Testbench top for the frame parser: clock, reset, byte stimulus, output stalls.
// Depends on lcfp_pkg, length_crc_frame_parser and length_crc_frame_parser_checker.
module length_crc_frame_parser_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lcfp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    logic [7:0]  frame_buf [$];

    always #6 clk = ~clk;

    length_crc_frame_parser u_dut (.*);

    length_crc_frame_parser_checker u_chk (.*);

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
    end

    // valid stays high after acceptance until the next item or an idle cycle
    task automatic send_item(logic [7:0] b, logic fl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= fl;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // builds and sends a frame of data length dl; corrupts the CRC when bad is set
    task automatic send_frame(int dl, logic [7:0] fc, logic bad);
        logic [15:0] c;
        frame_buf.delete();
        frame_buf.push_back(FRAME_HEADER);
        frame_buf.push_back(8'(dl + 5));
        frame_buf.push_back(fc);
        for (int i = 0; i < dl; i++)
            frame_buf.push_back(8'($urandom));
        c = CRC_INIT;
        foreach (frame_buf[i])
            c = crc_byte(c, frame_buf[i]);
        if (bad)
            c ^= 16'(1 << $urandom_range(15));
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
        foreach (frame_buf[i])
            send_item(frame_buf[i], 1'b0);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic random_traffic(int n);
        int k;
        for (int i = 0; i < n; )
        begin
            k = $urandom_range(99);
            if (k < 60)
            begin
                k = ($urandom_range(9) == 0) ? 58 : $urandom_range(8);
                send_frame(k, 8'($urandom), $urandom_range(7) == 0);
                i += k + 5;
            end
            else if (k < 95)
            begin
                send_item(($urandom_range(3) == 0) ? FRAME_HEADER : 8'($urandom), 1'b0);
                i++;
            end
            else
            begin
                send_item(8'($urandom), 1'b1);
                i++;
            end
        end
    endtask

    initial
    begin
        #20ms;
        $display("length_crc_frame_parser test failed");
        $finish;
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: empty frame, extremes of function code and length
        send_frame(0, 8'h00, 1'b0);
        send_frame(1, 8'hFF, 1'b0);
        send_frame(2, 8'hA5, 1'b1);
        send_item(8'h22, 1'b0);
        send_item(8'h04, 1'b0);
        send_item(8'h22, 1'b0);
        send_item(8'hFF, 1'b1);
        send_frame(58, 8'h5A, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_frame(0, 8'h11, 1'b0);
        send_frame(0, 8'h12, 1'b0);
        drain();
        // sender paused until everything arrived; then a long receiver hold-off
        hold_cycles <= 400;
        random_traffic(40);
        drain();
        random_traffic(60);
        send_idle_pct = 71;
        random_traffic(60);
        send_idle_pct = 0;
        recv_stall_pct = 71;
        random_traffic(60);
        send_idle_pct = 16;
        recv_stall_pct = 16;
        random_traffic(60);
        send_item(8'h00, 1'b1);
        drain();
        if (fail_count == 0)
            $display("length_crc_frame_parser test passed");
        else
            $display("length_crc_frame_parser test failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/lcfp_pkg.sv
sv/lcfp_front.sv
sv/lcfp_engine.sv
sv/length_crc_frame_parser.sv
dv/length_crc_frame_parser_checker.sv
dv/length_crc_frame_parser_test.sv
